@@ src/char_lcd_nibble_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer assertion macros
// Clocked assertion wrappers with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent |-> consequent in the same cycle
`define LCDNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdns assertion failed");

// antecedent |=> consequent in the next cycle
`define LCDNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcdns assertion failed");

`else

`define LCDNS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LCDNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/lcdns_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types and constants shared by the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

    // request opcodes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_CURSOR = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_HOME   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SETUP  = 2'd0;
    localparam logic [1:0] CFG_PULSE  = 2'd1;
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    localparam logic [15:0] RST_SETUP  = 16'd20;
    localparam logic [15:0] RST_PULSE  = 16'd20;
    localparam logic [15:0] RST_SETTLE = 16'd300;

    // LCD command bytes
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] ROW1_OFFSET    = 8'h40;
    localparam logic [6:0] ROW_LEN        = 7'd40;

    // raw init nibbles and timing
    localparam logic [3:0]  NIB_WAKE      = 4'h3;
    localparam logic [3:0]  NIB_4BIT      = 4'h2;
    localparam logic [15:0] INIT_EDGE     = 16'd50;
    localparam logic [15:0] INIT_WAIT0    = 16'd4500;
    localparam logic [15:0] INIT_WAIT1    = 16'd1000;
    localparam logic [15:0] INIT_WAIT2    = 16'd100;

    // nibble indexes within an init or byte request
    localparam logic [3:0] IDX_RAW_LAST   = 4'd3;
    localparam logic [3:0] IDX_FUNC_SET   = 4'd4;
    localparam logic [3:0] IDX_CLEAR      = 4'd6;
    localparam logic [3:0] IDX_INIT_LAST  = 4'd9;
    localparam logic [3:0] IDX_BYTE_LAST  = 4'd1;

    // phase codes within one nibble
    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_PULSE  = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;

    typedef struct packed {
        logic       init;
        logic [3:0] nib_idx;
        logic [1:0] phase;
    } t_step;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic        en;
        logic [15:0] hold;
    } t_phase;

    typedef struct packed {
        logic [15:0] setup;
        logic [15:0] pulse;
        logic [15:0] settle;
    } t_holds;

    typedef struct packed {
        logic       known;
        logic       init;
        logic       rs;
        logic [7:0] byte_val;
    } t_req;

endpackage

@@ src/char_lcd_nibble_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Expands LCD requests into 4-bit bus pin phases, one phase per cycle.
//
//  channel  | signals                                        | handshake
//  ---------+------------------------------------------------+------------------
//  request  | i_opcode i_byte_value i_column i_row           | start && !busy
//  phase    | o_reg_select o_data_nibble o_enable_level      | o_phase_valid
//           | o_hold_units o_last_phase                      |
//  config   | i_cfg_idx i_cfg_data                           | i_cfg_we
//
// A request is taken when start is high and busy is low; busy then stays high
// while the shared phase unit forms the phases, one phase per cycle, and each
// phase is registered and appears on the outputs in the cycle after it is
// formed. A new request can be taken while the last phase is on the outputs.
// Opcodes 6 and 7 are taken and yield no phases. Synchronous reset clears the
// sequencer and loads the default hold times. The receiver cannot stall.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic [6:0]  i_column,
    input  logic        i_row,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_phase_valid,
    output logic        o_reg_select,
    output logic [3:0]  o_data_nibble,
    output logic        o_enable_level,
    output logic [15:0] o_hold_units,
    output logic        o_last_phase
);

    `include "char_lcd_nibble_sequencer_assert.svh"

    lcdns_pkg::t_req   req;
    lcdns_pkg::t_phase phase;
    lcdns_pkg::t_holds r_holds;
    lcdns_pkg::t_step  r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_rs;
    logic [7:0]        r_byte;
    lcdns_pkg::t_phase r_out;
    logic              r_out_valid;
    logic              r_out_last;
    logic              accept;
    logic              step_last;

    lcdns_req_decode u_decode (
        .i_opcode     (i_opcode),
        .i_byte_value (i_byte_value),
        .i_column     (i_column),
        .i_row        (i_row),
        .o_req        (req)
    );

    lcdns_phase_gen u_phase (
        .i_step  (r_step),
        .i_rs    (r_rs),
        .i_byte  (r_byte),
        .i_holds (r_holds),
        .o_phase (phase)
    );

    assign accept    = start && !r_busy;
    assign step_last = (r_step.phase == lcdns_pkg::PH_SETTLE) &&
                       (r_step.nib_idx == (r_step.init ? lcdns_pkg::IDX_INIT_LAST
                                                        : lcdns_pkg::IDX_BYTE_LAST));

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (accept) begin
            n_busy         = req.known;
            n_step.init    = req.init;
            n_step.nib_idx = 4'd0;
            n_step.phase   = lcdns_pkg::PH_SETUP;
        end else if (r_busy) begin
            if (step_last) begin
                n_busy = 1'b0;
            end else if (r_step.phase == lcdns_pkg::PH_SETTLE) begin
                n_step.phase   = lcdns_pkg::PH_SETUP;
                n_step.nib_idx = r_step.nib_idx + 4'd1;
            end else begin
                n_step.phase   = r_step.phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_holds.setup  <= lcdns_pkg::RST_SETUP;
            r_holds.pulse  <= lcdns_pkg::RST_PULSE;
            r_holds.settle <= lcdns_pkg::RST_SETTLE;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= r_busy;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lcdns_pkg::CFG_SETUP:  r_holds.setup  <= i_cfg_data;
                    lcdns_pkg::CFG_PULSE:  r_holds.pulse  <= i_cfg_data;
                    lcdns_pkg::CFG_SETTLE: r_holds.settle <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rs   <= req.rs;
            r_byte <= req.byte_val;
        end
        r_out      <= phase;
        r_out_last <= step_last;
    end

    assign busy           = r_busy;
    assign o_phase_valid  = r_out_valid;
    assign o_reg_select   = r_out.rs;
    assign o_data_nibble  = r_out.nibble;
    assign o_enable_level = r_out.en;
    assign o_hold_units   = r_out.hold;
    assign o_last_phase   = r_out_valid && r_out_last;

    // last phase on the pins means the sequencer is free
    `LCDNS_ASSERT_SAME(a_last_frees, i_clk, i_rst_n, o_last_phase, !busy)
    // every busy cycle yields a phase
    `LCDNS_ASSERT_NEXT(a_busy_emits, i_clk, i_rst_n, busy, o_phase_valid)
    // no gaps inside a request
    `LCDNS_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, o_phase_valid && !o_last_phase, o_phase_valid)
    // enable high is followed by enable low on the same nibble
    `LCDNS_ASSERT_NEXT(a_pulse_fall, i_clk, i_rst_n, o_phase_valid && o_enable_level, o_phase_valid && !o_enable_level && $stable(o_data_nibble))

endmodule

@@ src/lcdns_req_decode.sv @@
// ----------------------------------------------------------------------------
// lcdns_req_decode
// Decodes a request into the byte to send, register select and init flag;
// forms the set-cursor command with row wrap.
// ----------------------------------------------------------------------------
module lcdns_req_decode (
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_byte_value,
    input  logic [6:0]        i_column,
    input  logic              i_row,
    output lcdns_pkg::t_req   o_req
);

    logic       wrap;
    logic [6:0] col_w;
    logic [7:0] cursor_cmd;

    assign wrap       = (i_column > lcdns_pkg::ROW_LEN) && !i_row;
    assign col_w      = wrap ? ((i_column - lcdns_pkg::ROW_LEN) | 7'h40) : i_column;
    assign cursor_cmd = ({1'b0, col_w} + (i_row ? lcdns_pkg::ROW1_OFFSET : 8'h00))
                        | lcdns_pkg::CMD_SET_DDRAM;

    always_comb begin
        o_req.known    = 1'b1;
        o_req.init     = 1'b0;
        o_req.rs       = 1'b0;
        o_req.byte_val = 8'h00;
        unique case (i_opcode)
            lcdns_pkg::OP_INIT:   o_req.init     = 1'b1;
            lcdns_pkg::OP_CMD:    o_req.byte_val = i_byte_value;
            lcdns_pkg::OP_DATA: begin
                o_req.rs       = 1'b1;
                o_req.byte_val = i_byte_value;
            end
            lcdns_pkg::OP_CURSOR: o_req.byte_val = cursor_cmd;
            lcdns_pkg::OP_CLEAR:  o_req.byte_val = lcdns_pkg::CMD_CLEAR;
            lcdns_pkg::OP_HOME:   o_req.byte_val = lcdns_pkg::CMD_HOME;
            default:              o_req.known    = 1'b0;
        endcase
    end

endmodule

@@ src/lcdns_phase_gen.sv @@
// ----------------------------------------------------------------------------
// lcdns_phase_gen
// Shared phase unit: maps a sequencer step to the pin levels and hold time
// of one bus phase.
// ----------------------------------------------------------------------------
module lcdns_phase_gen (
    input  lcdns_pkg::t_step  i_step,
    input  logic              i_rs,
    input  logic [7:0]        i_byte,
    input  lcdns_pkg::t_holds i_holds,
    output lcdns_pkg::t_phase o_phase
);

    logic             raw;
    logic [7:0]       cur_byte;
    logic [3:0]       nibble;
    lcdns_pkg::t_holds holds;

    assign raw = i_step.init && (i_step.nib_idx <= lcdns_pkg::IDX_RAW_LAST);

    always_comb begin
        if (!i_step.init) begin
            cur_byte = i_byte;
        end else if (i_step.nib_idx < lcdns_pkg::IDX_CLEAR) begin
            cur_byte = lcdns_pkg::CMD_FUNC_SET;
        end else if (i_step.nib_idx < lcdns_pkg::IDX_FUNC_SET + 4'd4) begin
            cur_byte = lcdns_pkg::CMD_CLEAR;
        end else begin
            cur_byte = lcdns_pkg::CMD_DISP_ON;
        end
    end

    always_comb begin
        if (raw) begin
            nibble       = (i_step.nib_idx == lcdns_pkg::IDX_RAW_LAST) ?
                           lcdns_pkg::NIB_4BIT : lcdns_pkg::NIB_WAKE;
            holds.setup  = lcdns_pkg::INIT_EDGE;
            holds.pulse  = lcdns_pkg::INIT_EDGE;
            case (i_step.nib_idx[1:0])
                2'd0:    holds.settle = lcdns_pkg::INIT_WAIT0;
                2'd1:    holds.settle = lcdns_pkg::INIT_WAIT1;
                default: holds.settle = lcdns_pkg::INIT_WAIT2;
            endcase
        end else begin
            // even index carries the high nibble
            nibble = i_step.nib_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
            holds  = i_holds;
        end
    end

    always_comb begin
        o_phase.rs     = i_step.init ? 1'b0 : i_rs;
        o_phase.nibble = nibble;
        unique case (i_step.phase)
            lcdns_pkg::PH_SETUP: begin
                o_phase.en   = 1'b0;
                o_phase.hold = holds.setup;
            end
            lcdns_pkg::PH_PULSE: begin
                o_phase.en   = 1'b1;
                o_phase.hold = holds.pulse;
            end
            default: begin
                o_phase.en   = 1'b0;
                o_phase.hold = holds.settle;
            end
        endcase
    end

endmodule
